FILE: rtl/core/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round functions of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  // initial chaining values
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  // round constants
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] FILL_TOP = 6'd63;
  localparam logic [6:0] RND_LAST = 7'd79;
  localparam logic [6:0] RND_Q1   = 7'd20;
  localparam logic [6:0] RND_Q2   = 7'd40;
  localparam logic [6:0] RND_Q3   = 7'd60;

  // request payloads
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_w0;
    logic [31:0] digest_w1;
    logic [31:0] digest_w2;
    logic [31:0] digest_w3;
    logic [31:0] digest_w4;
  } out_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_DONE
  } state_t;

  // source of a byte shifted into the block buffer
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      push;
    byte_sel_t byte_sel;
    logic      count_len;
    logic      rnd_start;
    logic      rnd_step;
    logic      chain_add;
    logic      finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic blk_full;
    logic at_len_pos;
    logic last_round;
  } sts_t;

  // round logic function
  function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    if (rnd < RND_Q1) begin
      res = (b & c) | (~b & d);
    end else if (rnd < RND_Q2) begin
      res = b ^ c ^ d;
    end else if (rnd < RND_Q3) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  // round constant
  function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
    logic [31:0] res;
    if (rnd < RND_Q1) begin
      res = K0;
    end else if (rnd < RND_Q2) begin
      res = K1;
    end else if (rnd < RND_Q3) begin
      res = K2;
    end else begin
      res = K3;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sha1_dp.sv
// ----------------------------------------------------------------------------
// sha1_dp
// Datapath: block buffer doubling as schedule window, round registers,
// chaining words, length counter and digest output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_dp import sha1_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire in_t  in_data,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output out_t      out_data
);

  logic [511:0] buf_r, buf_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [60:0]  len_r, len_nxt;
  logic [6:0]   rnd_r, rnd_nxt;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0]  h0_r, h1_r, h2_r, h3_r, h4_r;
  logic [31:0]  h0_nxt, h1_nxt, h2_nxt, h3_nxt, h4_nxt;
  out_t         dig_r, dig_nxt;

  logic [63:0]  bit_len;
  logic [2:0]   len_shift;
  logic [7:0]   push_byte;
  logic [31:0]  w_cur, w_mix, w_new, round_sum;

  // byte source for the buffer
  assign bit_len   = {len_r, 3'b000};
  assign len_shift = ~fill_r[2:0];
  always_comb begin
    unique case (cmd.byte_sel)
      SEL_DATA: push_byte = in_data.data_byte;
      SEL_MARK: push_byte = PAD_MARK;
      SEL_ZERO: push_byte = 8'h00;
      SEL_LEN:  push_byte = bit_len[{len_shift, 3'b000} +: 8];
      default:  push_byte = 8'h00;
    endcase
  end

  // schedule taps: word 0 is the current word, new word enters at the tail
  assign w_cur     = buf_r[511:480];
  assign w_mix     = buf_r[95:64] ^ buf_r[255:224] ^ buf_r[447:416] ^ w_cur;
  assign w_new     = {w_mix[30:0], w_mix[31]};
  assign round_sum = {a_r[26:0], a_r[31:27]} + sha1_f(rnd_r, b_r, c_r, d_r) + e_r
                     + sha1_k(rnd_r) + w_cur;

  // buffer, fill count and length
  always_comb begin
    buf_nxt  = buf_r;
    fill_nxt = fill_r;
    len_nxt  = len_r;
    if (cmd.push) begin
      buf_nxt  = {buf_r[503:0], push_byte};
      fill_nxt = fill_r + 6'd1;
    end else if (cmd.rnd_step) begin
      buf_nxt = {buf_r[479:0], w_new};
    end
    if (cmd.count_len) begin
      len_nxt = len_r + 61'd1;
    end
    if (cmd.finish) begin
      len_nxt = '0;
    end
  end

  // round registers
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    c_nxt   = c_r;
    d_nxt   = d_r;
    e_nxt   = e_r;
    rnd_nxt = rnd_r;
    if (cmd.rnd_start) begin
      a_nxt   = h0_r;
      b_nxt   = h1_r;
      c_nxt   = h2_r;
      d_nxt   = h3_r;
      e_nxt   = h4_r;
      rnd_nxt = '0;
    end else if (cmd.rnd_step) begin
      a_nxt   = round_sum;
      b_nxt   = a_r;
      c_nxt   = {b_r[1:0], b_r[31:2]};
      d_nxt   = c_r;
      e_nxt   = d_r;
      rnd_nxt = rnd_r + 7'd1;
    end
  end

  // chaining words and digest register
  always_comb begin
    h0_nxt  = h0_r;
    h1_nxt  = h1_r;
    h2_nxt  = h2_r;
    h3_nxt  = h3_r;
    h4_nxt  = h4_r;
    dig_nxt = dig_r;
    if (cmd.chain_add) begin
      h0_nxt = h0_r + a_r;
      h1_nxt = h1_r + b_r;
      h2_nxt = h2_r + c_r;
      h3_nxt = h3_r + d_r;
      h4_nxt = h4_r + e_r;
    end else if (cmd.finish) begin
      dig_nxt = '{digest_w0: h0_r, digest_w1: h1_r, digest_w2: h2_r,
                  digest_w3: h3_r, digest_w4: h4_r};
      h0_nxt  = IV0;
      h1_nxt  = IV1;
      h2_nxt  = IV2;
      h3_nxt  = IV3;
      h4_nxt  = IV4;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      rnd_r  <= '0;
      h0_r   <= IV0;
      h1_r   <= IV1;
      h2_r   <= IV2;
      h3_r   <= IV3;
      h4_r   <= IV4;
    end else begin
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
      rnd_r  <= rnd_nxt;
      h0_r   <= h0_nxt;
      h1_r   <= h1_nxt;
      h2_r   <= h2_nxt;
      h3_r   <= h3_nxt;
      h4_r   <= h4_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
    dig_r <= dig_nxt;
  end

  assign sts.blk_full   = (fill_r == FILL_TOP);
  assign sts.at_len_pos = (fill_r == LEN_POS);
  assign sts.last_round = (rnd_r == RND_LAST);
  assign out_data       = dig_r;

  // rounds run only on a complete block
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rnd_step |-> fill_r == '0)
    else $error("round step with partly filled buffer");

  // length bytes land in the last eight buffer positions
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && cmd.byte_sel == SEL_LEN) |-> fill_r[5:3] == 3'b111)
    else $error("length byte outside tail of block");

endmodule

`default_nettype wire

FILE: rtl/core/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// sha1_ctrl
// Controller: request handshake, byte pushing, padding sequence,
// compression rounds and digest hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_ctrl import sha1_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.has_byte && sts.blk_full) begin
            state_nxt = ST_ROUND;
            ret_nxt   = in_data.last ? ST_MARK : ST_IDLE;
          end else if (in_data.last) begin
            state_nxt = ST_MARK;
          end
        end
      end
      ST_ROUND: begin
        if (sts.last_round) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ret_r;
      end
      ST_MARK: begin
        if (sts.blk_full) begin
          state_nxt = ST_ROUND;
          ret_nxt   = ST_ZERO;
        end else begin
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (sts.at_len_pos) begin
          state_nxt = ST_LEN;
        end else if (sts.blk_full) begin
          state_nxt = ST_ROUND;
          ret_nxt   = ST_ZERO;
        end
      end
      ST_LEN: begin
        if (sts.blk_full) begin
          state_nxt = ST_ROUND;
          ret_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '{push: 1'b0, byte_sel: SEL_DATA, count_len: 1'b0, rnd_start: 1'b0,
            rnd_step: 1'b0, chain_add: 1'b0, finish: 1'b0};
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_data.has_byte) begin
          cmd.push      = 1'b1;
          cmd.byte_sel  = SEL_DATA;
          cmd.count_len = 1'b1;
          cmd.rnd_start = sts.blk_full;
        end
      end
      ST_ROUND: begin
        cmd.rnd_step = 1'b1;
      end
      ST_UPDATE: begin
        cmd.chain_add = 1'b1;
      end
      ST_MARK: begin
        cmd.push      = 1'b1;
        cmd.byte_sel  = SEL_MARK;
        cmd.rnd_start = sts.blk_full;
      end
      ST_ZERO: begin
        if (!sts.at_len_pos) begin
          cmd.push      = 1'b1;
          cmd.byte_sel  = SEL_ZERO;
          cmd.rnd_start = sts.blk_full;
        end
      end
      ST_LEN: begin
        cmd.push      = 1'b1;
        cmd.byte_sel  = SEL_LEN;
        cmd.rnd_start = sts.blk_full;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        cmd.push = 1'b0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a digest appears only out of the done state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("digest raised outside done state");

  // the chaining add follows the final round
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPDATE |-> ($past(state_r) == ST_ROUND && $past(sts.last_round)))
    else $error("chaining add without finished rounds");

  // a compression starts only from a full block
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rnd_start |-> (cmd.push && sts.blk_full))
    else $error("compression started on partial block");

endmodule

`default_nettype wire

FILE: rtl/core/sha1_hash_engine.sv
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 over a byte stream: one byte per request, digest on the last one.
// ----------------------------------------------------------------------------
//  channel  ports                          payload
//  in       in_valid / in_stall / in_data  data_byte, has_byte, last
//  out      out_valid / out_stall / out_data  digest_w0 .. digest_w4
//
//  a byte request is pushed into the block buffer; every 64th byte adds a
//  compression (80 rounds on the single round unit plus the chaining add)
//  a last request adds the padding bytes, a step to reach the length
//  field, one or two compressions and the move of the digest into the
//  output register
//  in_stall is high whenever the controller is not idle
//  the output register holds one digest; a following message runs on and
//  waits in its final cycle while that digest is still stalled
//  synchronous reset loads the initial chaining values and clears counters
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_hash_engine import sha1_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hashing datapath
  sha1_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
